FILE: hdl/bldm_pkg.sv
// Shared types, operation codes and helpers for the bounded list deque.
package bldm_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 6;
  localparam int STAT_W  = 2;
  localparam int OP_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_MID   = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_MID   = 3'd5,
    OP_DUMP      = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    WH_FRONT = 2'd0,
    WH_BACK  = 2'd1,
    WH_MID   = 2'd2
  } where_t;

  typedef struct packed {
    cmd_kind_t kind;
    where_t    where;
  } cmd_t;

  function automatic where_t op_where(input op_t op);
    where_t w;
    unique case (op)
      OP_INS_FIRST, OP_DEL_FIRST: w = WH_FRONT;
      OP_INS_LAST,  OP_DEL_LAST:  w = WH_BACK;
      default:                    w = WH_MID;
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/bldm_datapath.sv
// Element cell array with parallel shift and rotate, and the element count.
module bldm_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bldm_pkg::cmd_t                    cmd,
  input  logic [bldm_pkg::VALUE_W-1:0]      value,
  output logic [$clog2(CAPACITY+1)-1:0]     count,
  output logic [bldm_pkg::VALUE_W-1:0]      head
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [bldm_pkg::VALUE_W-1:0] cell_r [CAPACITY];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] mid_w, pos_w;
  logic [IW-1:0] pos;

  always_comb begin
    mid_w = ((count_r - CW'(1)) >> 1) + CW'(1);
    pos_w = '0;
    if (cmd.kind == bldm_pkg::CMD_INS) begin
      case (cmd.where)
        bldm_pkg::WH_FRONT: pos_w = '0;
        bldm_pkg::WH_BACK:  pos_w = count_r;
        bldm_pkg::WH_MID:   pos_w = (count_r == '0) ? '0 : mid_w;
        default:            pos_w = '0;
      endcase
    end else begin
      case (cmd.where)
        bldm_pkg::WH_FRONT: pos_w = '0;
        bldm_pkg::WH_BACK:  pos_w = count_r - CW'(1);
        bldm_pkg::WH_MID:   pos_w = (count_r == CW'(1)) ? '0 : mid_w;
        default:            pos_w = '0;
      endcase
    end
    pos = IW'(pos_w);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [bldm_pkg::VALUE_W-1:0] below, above;

    if (i == 0) begin : g_first
      assign below = value;
    end else begin : g_inner_lo
      assign below = cell_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign above = cell_r[i];
    end else begin : g_inner_hi
      assign above = cell_r[i+1];
    end

    always_ff @(posedge clk) begin
      case (cmd.kind)
        bldm_pkg::CMD_INS: begin
          if (IW'(i) > pos) begin
            cell_r[i] <= below;
          end else if (IW'(i) == pos) begin
            cell_r[i] <= value;
          end
        end
        bldm_pkg::CMD_DEL: begin
          if (IW'(i) >= pos) begin
            cell_r[i] <= above;
          end
        end
        bldm_pkg::CMD_ROT: begin
          if (CW'(i) == count_r - CW'(1)) begin
            cell_r[i] <= cell_r[0];
          end else if (CW'(i) < count_r) begin
            cell_r[i] <= above;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.kind)
      bldm_pkg::CMD_INS: count_nxt = count_r + CW'(1);
      bldm_pkg::CMD_DEL: count_nxt = count_r - CW'(1);
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;
  assign head  = cell_r[0];

endmodule

FILE: hdl/bldm_ctrl.sv
// Operation sequencer with the registered result stage.
module bldm_ctrl #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  bldm_pkg::op_t                     op,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output bldm_pkg::status_t                 out_status,
  output logic [bldm_pkg::VALUE_W-1:0]      out_element,
  output logic                              out_last,
  output logic [bldm_pkg::OCC_W-1:0]        out_occupancy,
  output bldm_pkg::cmd_t                    cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  input  logic [bldm_pkg::VALUE_W-1:0]      head
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  bldm_pkg::status_t status_r, status_nxt;
  logic [bldm_pkg::VALUE_W-1:0] element_r, element_nxt;
  logic last_r, last_nxt;
  logic [bldm_pkg::OCC_W-1:0] occ_r, occ_nxt;

  logic slot_free, fire, load, full, empty, dump_last;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign fire      = in_tvalid && in_tready;
  assign full      = (count >= CW'(CAPACITY));
  assign empty     = (count == '0);
  assign dump_last = (idx_r == IW'(count - CW'(1)));

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    load        = 1'b0;
    status_nxt  = status_r;
    element_nxt = element_r;
    last_nxt    = last_r;
    occ_nxt     = occ_r;
    cmd.kind    = bldm_pkg::CMD_NONE;
    cmd.where   = bldm_pkg::op_where(op);

    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          load        = 1'b1;
          status_nxt  = bldm_pkg::ST_OK;
          element_nxt = '0;
          last_nxt    = 1'b1;
          occ_nxt     = bldm_pkg::OCC_W'(count);
          case (op) inside
            bldm_pkg::OP_INS_FIRST, bldm_pkg::OP_INS_LAST, bldm_pkg::OP_INS_MID: begin
              if (full) begin
                status_nxt = bldm_pkg::ST_FULL;
              end else begin
                cmd.kind = bldm_pkg::CMD_INS;
                occ_nxt  = bldm_pkg::OCC_W'(count + CW'(1));
              end
            end
            bldm_pkg::OP_DEL_FIRST, bldm_pkg::OP_DEL_LAST, bldm_pkg::OP_DEL_MID: begin
              if (empty) begin
                status_nxt = bldm_pkg::ST_EMPTY;
              end else begin
                cmd.kind = bldm_pkg::CMD_DEL;
                occ_nxt  = bldm_pkg::OCC_W'(count - CW'(1));
              end
            end
            bldm_pkg::OP_DUMP: begin
              if (empty) begin
                status_nxt = bldm_pkg::ST_EMPTY;
              end else begin
                load      = 1'b0;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          load        = 1'b1;
          status_nxt  = bldm_pkg::ST_OK;
          element_nxt = head;
          last_nxt    = dump_last;
          occ_nxt     = bldm_pkg::OCC_W'(count);
          cmd.kind    = bldm_pkg::CMD_ROT;
          idx_nxt     = idx_r + IW'(1);
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    element_r <= element_nxt;
    last_r    <= last_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_tvalid    = out_valid_r;
  assign out_status    = status_r;
  assign out_element   = element_r;
  assign out_last      = last_r;
  assign out_occupancy = occ_r;

endmodule

FILE: hdl/bounded_list_deque_with_middle_top.sv
// Top level of the bounded list deque with middle insert and delete.
// Usage:
//   The in_ stream carries one operation per beat: insert at front, back or
//   middle, delete at front, back or middle, or dump. The out_ stream returns
//   one beat per insert or delete (status, occupancy after the operation,
//   tlast high) and one beat per stored element for a dump, head to tail,
//   tlast on the tail; a dump of an empty list returns one empty beat.
// Timing and throughput:
//   Insert and delete shift the whole cell array at once; the registered
//   result beat appears in the cycle after acceptance and a new operation
//   is taken every cycle while the receiver keeps up.
//   A dump rotates the array one cell per cycle while the receiver keeps
//   up, so the head cell feeds the output; the array ends back in order.
//   No new operation is taken during a dump.
// Reset:
//   rst_n low empties the list; stored values are not cleared.
// Stall:
//   A held result beat stays in the output register; one more operation may
//   be taken only in the cycle that beat leaves, and a dump pauses with it.
module bounded_list_deque_with_middle_top #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] op, [34:3] value, [39:35] zero
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [39:0] out_tdata,  // [1:0] status, [33:2] element, [39:34] occupancy
  output logic        out_tlast
);

  bldm_pkg::cmd_t                   cmd;
  bldm_pkg::op_t                    op;
  bldm_pkg::status_t                status;
  logic [bldm_pkg::VALUE_W-1:0]     value, element, head;
  logic [bldm_pkg::OCC_W-1:0]       occupancy;
  logic [$clog2(CAPACITY+1)-1:0]    count;

  assign op    = bldm_pkg::op_t'(in_tdata[2:0]);
  assign value = in_tdata[34:3];

  bldm_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .op            (op),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_status    (status),
    .out_element   (element),
    .out_last      (out_tlast),
    .out_occupancy (occupancy),
    .cmd           (cmd),
    .count         (count),
    .head          (head)
  );

  bldm_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .value (value),
    .count (count),
    .head  (head)
  );

  assign out_tdata = {occupancy, element, status};

endmodule

FILE: hdl/bldm_checker.sv
// Port-level checks for the bounded list deque, bound to the top level.
module bldm_checker #(
  parameter int CAPACITY = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tready,
  input logic        out_tvalid,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("operation accepted in the middle of a dump");

  a_mid_dump_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[1:0] == bldm_pkg::ST_OK)
    else $error("non-final beat with error status");

  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == bldm_pkg::ST_FULL |->
      out_tdata[39:34] == bldm_pkg::OCC_W'(CAPACITY))
    else $error("full status with list not at capacity");

  a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == bldm_pkg::ST_EMPTY |->
      out_tdata[39:34] == '0 && out_tdata[33:2] == '0 && out_tlast)
    else $error("empty status with elements present");

endmodule

bind bounded_list_deque_with_middle_top bldm_checker #(.CAPACITY(CAPACITY)) u_bldm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tready (out_tready),
  .out_tvalid (out_tvalid),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
